@@ design/kst_pkg.sv @@
// shared types and constants for the k-th smallest tracker
`timescale 1ns / 1ps
package kst_pkg;
    localparam int unsigned CAPACITY_DEF  = 256;
    localparam int unsigned KEY_WIDTH_DEF = 32;
    localparam int unsigned RANK_W        = 9;
    localparam int unsigned COUNT_W       = 9;
    localparam int unsigned STATUS_W      = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_WR,
        S_LMAX_SCAN,
        S_LMAX_LAST,
        S_LMAX_FIX,
        S_UMIN_SCAN,
        S_UMIN_LAST,
        S_UMIN_FIX,
        S_KTH_SCAN,
        S_KTH_LAST,
        S_DONE
    } kst_state_t;
endpackage

@@ design/kst_heap_mem.sv @@
// one key store: single write port, one registered read port
`timescale 1ns / 1ps
module kst_heap_mem
    import kst_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [KEY_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [KEY_WIDTH-1:0] rd_data
);
    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end
endmodule

@@ design/kth_smallest_tracker_core.sv @@
// top level: k-th smallest tracker over two key stores and a scan sequencer
`timescale 1ns / 1ps
// Keeps a multiset of signed keys as a lower store (the K smallest) and an
// upper store, each a one-port-read memory. One beat is processed at a time:
// an insert into a store that is not full writes the key, and if the lower
// store overflows scans it for its largest key and moves it up; a remove from
// a non-empty store scans the lower store for its largest, then the upper store
// (if not empty) for its smallest. A final scan of the lower store gives the
// K-th smallest. Each scan reads one entry a cycle, so the time from acceptance
// to the result beat grows with the store counts, set by the single memory read
// port. s_ready returns the cycle after the result beat is taken.
// Writing the rank through cfg_wr_en empties the store.
module kth_smallest_tracker_core
    import kst_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [RANK_W-1:0]           cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic signed [KEY_WIDTH-1:0] s_key_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [STATUS_W-1:0]         m_status,
    output logic signed [KEY_WIDTH-1:0] m_removed_key,
    output logic                        m_removed_was_kth,
    output logic signed [KEY_WIDTH-1:0] m_kth_key,
    output logic                        m_kth_valid,
    output logic [COUNT_W-1:0]          m_key_count
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    kst_state_t state_reg, state_next;

    logic [RANK_W-1:0] k_reg;
    logic [CW-1:0] k_eff;
    logic [CW-1:0] lcnt_reg, lcnt_next, ucnt_reg, ucnt_next;
    logic cmd_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic signed [KEY_WIDTH-1:0] rem_reg, rem_next;
    logic was_kth_reg, was_kth_next;
    // scan bookkeeping
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] best_at_reg, best_at_next;
    logic signed [KEY_WIDTH-1:0] best_reg, best_next;
    logic [AW-1:0] cand_at_reg, cand_at_next;
    logic signed [KEY_WIDTH-1:0] last_reg, last_next;
    logic last_pend_reg, last_pend_next;
    // output register
    logic out_v_reg;
    logic signed [KEY_WIDTH-1:0] kth_reg, kth_next;
    logic kvalid_reg, kvalid_next;

    // memory ports
    logic l_we, u_we;
    logic [AW-1:0] l_wa, u_wa, l_ra, u_ra;
    logic signed [KEY_WIDTH-1:0] l_wd, u_wd, l_rd, u_rd;

    kst_heap_mem #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_lower (
        .aclk(aclk), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
        .rd_addr(l_ra), .rd_data(l_rd)
    );
    kst_heap_mem #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_upper (
        .aclk(aclk), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
        .rd_addr(u_ra), .rd_data(u_rd)
    );

    // rank clamp
    always_comb begin
        if (k_reg == '0) begin
            k_eff = CW'(1);
        end else if (32'(k_reg) > CAPACITY) begin
            k_eff = CAP_C;
        end else begin
            k_eff = CW'(k_reg);
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_v_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_command == CMD_INSERT) begin
                        state_next = ((lcnt_reg + ucnt_reg) >= CAP_C) ? S_KTH_SCAN
                                                                       : S_INS_WR;
                    end else begin
                        state_next = (lcnt_reg == '0) ? S_KTH_SCAN : S_LMAX_SCAN;
                    end
                end
            end
            S_INS_WR:    state_next = (lcnt_reg >= k_eff) ? S_LMAX_SCAN : S_KTH_SCAN;
            S_LMAX_SCAN: state_next = (idx_reg >= lcnt_reg) ? S_LMAX_LAST : S_LMAX_SCAN;
            S_LMAX_LAST: state_next = S_LMAX_FIX;
            S_LMAX_FIX: begin
                if (cmd_reg == CMD_REMOVE && ucnt_reg != '0) begin
                    state_next = S_UMIN_SCAN;
                end else begin
                    state_next = S_KTH_SCAN;
                end
            end
            S_UMIN_SCAN: state_next = (idx_reg >= ucnt_reg) ? S_UMIN_LAST : S_UMIN_SCAN;
            S_UMIN_LAST: state_next = S_UMIN_FIX;
            S_UMIN_FIX:  state_next = S_KTH_SCAN;
            S_KTH_SCAN: begin
                if (lcnt_reg != k_eff) begin
                    state_next = S_DONE;
                end else if (idx_reg >= lcnt_reg) begin
                    state_next = S_KTH_LAST;
                end
            end
            S_KTH_LAST:  state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        lcnt_next = lcnt_reg;
        ucnt_next = ucnt_reg;
        st_next = st_reg;
        rem_next = rem_reg;
        was_kth_next = was_kth_reg;
        idx_next = idx_reg;
        best_at_next = best_at_reg;
        best_next = best_reg;
        cand_at_next = cand_at_reg;
        last_next = last_reg;
        last_pend_next = 1'b0;
        kth_next = kth_reg;
        kvalid_next = kvalid_reg;
        l_we = 1'b0; l_wa = '0; l_wd = key_reg; l_ra = '0;
        u_we = 1'b0; u_wa = '0; u_wd = key_reg; u_ra = '0;
        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                // in idle, result fields only change when a new beat is taken
                if (s_valid && s_ready) begin
                    st_next = ST_OK;
                    rem_next = '0;
                    was_kth_next = 1'b0;
                    if (s_command == CMD_INSERT && (lcnt_reg + ucnt_reg) >= CAP_C) begin
                        st_next = ST_FULL;
                    end else if (s_command == CMD_REMOVE && lcnt_reg == '0) begin
                        st_next = ST_EMPTY;
                    end else if (s_command == CMD_REMOVE) begin
                        was_kth_next = (lcnt_reg == k_eff);
                    end
                end
            end
            S_INS_WR: begin
                l_we = 1'b1;
                l_wa = AW'(lcnt_reg);
                l_wd = key_reg;
                lcnt_next = lcnt_reg + 1'b1;
            end
            // read lower entries in order, compare the one returned last cycle
            S_LMAX_SCAN, S_KTH_SCAN: begin
                l_ra = AW'(idx_reg);
                if (last_pend_reg) begin
                    if (idx_reg == CW'(1) || best_reg < l_rd) begin
                        best_next = l_rd;
                        best_at_next = cand_at_reg;
                    end
                end
                cand_at_next = AW'(idx_reg);
                last_next = l_rd;
                last_pend_next = (idx_reg < lcnt_reg);
                idx_next = idx_reg + 1'b1;
            end
            S_LMAX_LAST, S_KTH_LAST: begin
                // tail was captured in the final scan cycle
                if (last_pend_reg && (idx_reg == CW'(1) || best_reg < l_rd)) begin
                    best_next = l_rd;
                    best_at_next = cand_at_reg;
                end
                if (state_reg == S_KTH_LAST) begin
                    if (last_pend_reg && (idx_reg == CW'(1) || best_reg < l_rd)) begin
                        kth_next = l_rd;
                    end else begin
                        kth_next = best_reg;
                    end
                end
            end
            S_LMAX_FIX: begin
                // move tail into the hole, hand the maximum on
                l_we = 1'b1;
                l_wa = best_at_reg;
                l_wd = last_reg;
                lcnt_next = lcnt_reg - 1'b1;
                idx_next = '0;
                if (cmd_reg == CMD_INSERT) begin
                    u_we = 1'b1;
                    u_wa = AW'(ucnt_reg);
                    u_wd = best_reg;
                    ucnt_next = ucnt_reg + 1'b1;
                end else begin
                    rem_next = best_reg;
                end
            end
            S_UMIN_SCAN: begin
                u_ra = AW'(idx_reg);
                if (last_pend_reg) begin
                    if (idx_reg == CW'(1) || u_rd < best_reg) begin
                        best_next = u_rd;
                        best_at_next = cand_at_reg;
                    end
                end
                cand_at_next = AW'(idx_reg);
                last_next = u_rd;
                last_pend_next = (idx_reg < ucnt_reg);
                idx_next = idx_reg + 1'b1;
            end
            S_UMIN_LAST: begin
                if (last_pend_reg && (idx_reg == CW'(1) || u_rd < best_reg)) begin
                    best_next = u_rd;
                    best_at_next = cand_at_reg;
                end
            end
            S_UMIN_FIX: begin
                u_we = 1'b1;
                u_wa = best_at_reg;
                u_wd = last_reg;
                ucnt_next = ucnt_reg - 1'b1;
                l_we = 1'b1;
                l_wa = AW'(lcnt_reg);
                l_wd = best_reg;
                lcnt_next = lcnt_reg + 1'b1;
                idx_next = '0;
            end
            S_DONE: begin
                kvalid_next = (lcnt_reg == k_eff);
                if (lcnt_reg != k_eff) begin
                    kth_next = '0;
                end
            end
            default: ;
        endcase
        if (state_reg == S_LMAX_FIX || state_reg == S_UMIN_FIX || state_reg == S_INS_WR) begin
            idx_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg <= RANK_W'(1);
            lcnt_reg <= '0;
            ucnt_reg <= '0;
            out_v_reg <= 1'b0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_pend_reg <= last_pend_next;
            if (cfg_wr_en) begin
                k_reg <= cfg_wr_data;
                lcnt_reg <= '0;
                ucnt_reg <= '0;
            end else begin
                lcnt_reg <= lcnt_next;
                ucnt_reg <= ucnt_next;
            end
            if (state_reg == S_DONE) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            key_reg <= s_key_in;
        end
        st_reg <= st_next;
        rem_reg <= rem_next;
        was_kth_reg <= was_kth_next;
        idx_reg <= idx_next;
        best_at_reg <= best_at_next;
        best_reg <= best_next;
        cand_at_reg <= cand_at_next;
        last_reg <= last_next;
        kth_reg <= kth_next;
        kvalid_reg <= kvalid_next;
    end

    assign m_valid = out_v_reg;
    assign m_status = st_reg;
    assign m_removed_key = rem_reg;
    assign m_removed_was_kth = was_kth_reg;
    assign m_kth_key = kth_reg;
    assign m_kth_valid = kvalid_reg;
    assign m_key_count = COUNT_W'(lcnt_reg + ucnt_reg);
endmodule

@@ design/kst_checker.sv @@
// port-level checker for the tracker, bound to the top level
`timescale 1ns / 1ps
module kst_checker
    import kst_pkg::*;
#(
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [STATUS_W-1:0]  m_status,
    input logic [KEY_WIDTH-1:0] m_removed_key,
    input logic                 m_removed_was_kth,
    input logic                 m_kth_valid,
    input logic [KEY_WIDTH-1:0] m_kth_key
);
    // result stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // waiting result keeps its payload
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_status) && $stable(m_removed_key)
            && $stable(m_removed_was_kth) && $stable(m_kth_key) && $stable(m_kth_valid))
        else $error("result changed while waiting");
    // no new beat while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("beat taken with result pending");
    // failed operations remove nothing
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_removed_key == '0 && !m_removed_was_kth)
        else $error("failed op removed a key");
    // absent k-th reads as zero
    a_kth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kth_valid |-> m_kth_key == '0) else $error("stale kth key");
endmodule

bind kth_smallest_tracker_core kst_checker #(.KEY_WIDTH(KEY_WIDTH)) u_kst_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_removed_key(m_removed_key), .m_removed_was_kth(m_removed_was_kth),
    .m_kth_valid(m_kth_valid), .m_kth_key(m_kth_key)
);
